>>> src/ubsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubsm_pkg
// shared types and constants of the ups battery status monitor
// ----------------------------------------------------------------------------
package ubsm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_VOLTAGE    = 3'd0,
    CFG_MAX_VOLTAGE    = 3'd1,
    CFG_AVG_TIME       = 3'd2,
    CFG_REMAIN_LIMIT   = 3'd3,
    CFG_FULL_LEVEL     = 3'd4,
    CFG_REPORT_INTERVAL = 3'd5,
    CFG_RESTORE_TIMEOUT = 3'd6,
    CFG_LOW_LOAD_LIMIT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] min_voltage_mv;
    logic [15:0] max_voltage_mv;
    logic [15:0] avg_time_to_empty_s;
    logic [15:0] remain_time_limit_s;
    logic [7:0]  full_charge_level;
    logic [7:0]  report_interval;
    logic [9:0]  restore_timeout_ticks;
    logic [15:0] low_load_limit_mw;
  } cfg_t;

  localparam logic [15:0] MIN_VOLTAGE_RST     = 16'd11200;
  localparam logic [15:0] MAX_VOLTAGE_RST     = 16'd13800;
  localparam logic [15:0] AVG_TIME_RST        = 16'd7200;
  localparam logic [15:0] REMAIN_LIMIT_RST    = 16'd600;
  localparam logic [7:0]  FULL_LEVEL_RST      = 8'd100;
  localparam logic [7:0]  REPORT_INTERVAL_RST = 8'd26;
  localparam logic [9:0]  RESTORE_TIMEOUT_RST = 10'd600;
  localparam logic [15:0] LOW_LOAD_LIMIT_RST  = 16'd5000;

  // percent division: eight quotient bits, one per cycle
  localparam int unsigned DIV_STEPS = 8;
  localparam logic [2:0]  DIV_LAST  = 3'(DIV_STEPS - 1);

  // n / 100 as (n * ceil(2^31 / 100)) >> 31, exact for n below 2^25
  localparam logic [24:0] RECIP_100   = 25'd21474837;
  localparam int unsigned RECIP_SHIFT = 31;

  // load power in units of 0.1 mW: mA * 122
  localparam logic signed [24:0] MW_PER_MA_X10 = 25'sd122;
  localparam logic [19:0]        LIMIT_SCALE   = 20'd10;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_charge;
    logic mul_recip;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL1 = 6'b001000,
    S_MUL2 = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

>>> src/ubsm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubsm_cfg
// configuration register file, written through the cfg transaction port
// ----------------------------------------------------------------------------
module ubsm_cfg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  output ubsm_pkg::cfg_t       cfg
);

  // a write offered during reset would be dropped, so hold it off
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_voltage_mv        <= ubsm_pkg::MIN_VOLTAGE_RST;
      cfg.max_voltage_mv        <= ubsm_pkg::MAX_VOLTAGE_RST;
      cfg.avg_time_to_empty_s   <= ubsm_pkg::AVG_TIME_RST;
      cfg.remain_time_limit_s   <= ubsm_pkg::REMAIN_LIMIT_RST;
      cfg.full_charge_level     <= ubsm_pkg::FULL_LEVEL_RST;
      cfg.report_interval       <= ubsm_pkg::REPORT_INTERVAL_RST;
      cfg.restore_timeout_ticks <= ubsm_pkg::RESTORE_TIMEOUT_RST;
      cfg.low_load_limit_mw     <= ubsm_pkg::LOW_LOAD_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ubsm_pkg::cfg_idx_t'(cfg_index))
        ubsm_pkg::CFG_MIN_VOLTAGE:     cfg.min_voltage_mv        <= cfg_data;
        ubsm_pkg::CFG_MAX_VOLTAGE:     cfg.max_voltage_mv        <= cfg_data;
        ubsm_pkg::CFG_AVG_TIME:        cfg.avg_time_to_empty_s   <= cfg_data;
        ubsm_pkg::CFG_REMAIN_LIMIT:    cfg.remain_time_limit_s   <= cfg_data;
        ubsm_pkg::CFG_FULL_LEVEL:      cfg.full_charge_level     <= cfg_data[7:0];
        ubsm_pkg::CFG_REPORT_INTERVAL: cfg.report_interval       <= cfg_data[7:0];
        ubsm_pkg::CFG_RESTORE_TIMEOUT: cfg.restore_timeout_ticks <= cfg_data[9:0];
        ubsm_pkg::CFG_LOW_LOAD_LIMIT:  cfg.low_load_limit_mw     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ubsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubsm_ctrl
// sequencer: accept, prep, divide, two multiplies, then finish into the output slot
// ----------------------------------------------------------------------------
module ubsm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ubsm_pkg::sts_t sts,
  output ubsm_pkg::cmd_t      cmd
);

  ubsm_pkg::state_t state, state_next;
  logic [2:0]       div_cnt, div_cnt_next;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      ubsm_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ubsm_pkg::S_PREP;
        end
      end
      ubsm_pkg::S_PREP: begin
        cmd.prep     = 1'b1;
        div_cnt_next = '0;
        state_next   = ubsm_pkg::S_DIV;
      end
      ubsm_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 3'd1;
        if (div_cnt == ubsm_pkg::DIV_LAST) begin
          state_next = ubsm_pkg::S_MUL1;
        end
      end
      ubsm_pkg::S_MUL1: begin
        cmd.mul_charge = 1'b1;
        state_next     = ubsm_pkg::S_MUL2;
      end
      ubsm_pkg::S_MUL2: begin
        cmd.mul_recip = 1'b1;
        state_next    = ubsm_pkg::S_FIN;
      end
      ubsm_pkg::S_FIN: begin
        // hold here until the output slot can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ubsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ubsm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ubsm_pkg::S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  // no tick is taken while reset is held
  assign in_stall = rst || (state != ubsm_pkg::S_IDLE);

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result finished while output slot occupied");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction");

endmodule
`default_nettype wire

>>> src/ubsm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubsm_dpath
// charge divider, runtime multiplies, status and report logic, output slot
// ----------------------------------------------------------------------------
module ubsm_dpath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ubsm_pkg::cfg_t     cfg,
  input  wire ubsm_pkg::cmd_t     cmd,
  output ubsm_pkg::sts_t          sts,
  input  wire logic               mains_present,
  input  wire logic [15:0]        bus_voltage_mv,
  input  wire logic signed [16:0] load_current_ma,
  input  wire logic signed [15:0] shutdown_delay_s,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              remaining_pct,
  output logic [15:0]             runtime_to_empty_s,
  output logic [7:0]              status_word,
  output logic                    send_report,
  output logic                    send_runtime,
  output logic                    relay_pulse,
  output logic signed [10:0]      restore_ticks_left
);

  // latched tick
  logic               in_mains;
  logic [15:0]        in_volt;
  logic signed [16:0] in_cur;
  logic signed [15:0] in_sdly;

  // divider
  logic        zero_span, sat;
  logic [23:0] part, dsr;
  logic [7:0]  quot;

  // multiplies
  logic [7:0]  rem_r;
  logic [23:0] prod1;
  logic [17:0] q_rt;
  logic        low_r;

  // persistent state
  logic [7:0]  prev_status, prev_remaining, interval_timer;
  logic [15:0] prev_runtime;
  logic        outage_seen;
  logic [10:0] restore_counter;

  // prep
  logic [15:0] v_clamp, v_delta, span;
  logic [23:0] num;
  logic [16:0] den;
  logic        span_ok;

  always_comb begin
    span_ok = cfg.max_voltage_mv > cfg.min_voltage_mv;
    v_clamp = (in_volt < cfg.min_voltage_mv) ? cfg.min_voltage_mv : in_volt;
    v_delta = v_clamp - cfg.min_voltage_mv;
    span    = cfg.max_voltage_mv - cfg.min_voltage_mv;
    num     = 24'(v_delta) * 24'd200 + 24'(span);
    den     = {span, 1'b0};
  end

  // divide step
  logic div_ge;
  assign div_ge = part >= dsr;

  // charge multiply and load power
  logic [7:0]         rem_c;
  logic signed [24:0] pwr;
  logic signed [24:0] lim;
  logic [48:0]        prod2;

  always_comb begin
    rem_c = zero_span ? 8'd0 : (sat ? 8'hFF : quot);
    pwr   = 25'(in_cur) * ubsm_pkg::MW_PER_MA_X10;
    lim   = $signed({5'b0, 20'(cfg.low_load_limit_mw) * ubsm_pkg::LIMIT_SCALE});
    prod2 = 49'(prod1) * 49'(ubsm_pkg::RECIP_100);
  end

  // finish
  logic [15:0] rt;
  logic        dis, rtl, sreq, full, report;
  logic [7:0]  st;
  logic [8:0]  timer_sum;
  logic [7:0]  timer_inc;
  logic [10:0] cnt_base, cnt_inc, ticks, counter_next;
  logic        seen_base, watch, watch_end, seen_next;

  always_comb begin
    rt        = (q_rt[17:16] != 2'b00) ? 16'hFFFF : q_rt[15:0];
    dis       = !in_mains;
    rtl       = dis && (rt < cfg.remain_time_limit_s);
    sreq      = in_sdly > 16'sd0;
    full      = rem_r == cfg.full_charge_level;
    st        = {1'b1, rtl | sreq, sreq, rtl, dis, full, in_mains, in_mains};
    timer_sum = {1'b0, interval_timer} + 9'd2;
    timer_inc = timer_sum[8] ? 8'hFF : timer_sum[7:0];
    report    = (st != prev_status) || (rem_r != prev_remaining) ||
                (rt != prev_runtime) || (timer_inc > cfg.report_interval);
    cnt_base  = dis ? 11'd0 : restore_counter;
    seen_base = dis | outage_seen;
    ticks     = {1'b0, cfg.restore_timeout_ticks} - cnt_base;
    cnt_inc   = cnt_base + 11'd1;
    watch     = seen_base && in_mains;
    watch_end = watch && ((cnt_inc > {1'b0, cfg.restore_timeout_ticks}) || low_r);
    seen_next = watch_end ? 1'b0 : seen_base;
    if (!watch) begin
      counter_next = cnt_base;
    end else if (watch_end) begin
      counter_next = '0;
    end else begin
      counter_next = cnt_inc;
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mains <= mains_present;
      in_volt  <= bus_voltage_mv;
      in_cur   <= load_current_ma;
      in_sdly  <= shutdown_delay_s;
    end
    if (cmd.prep) begin
      zero_span <= !span_ok;
      sat       <= {1'b0, num} >= {den, 8'b0};
      part      <= num;
      dsr       <= {den, 7'b0};
      quot      <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        part <= part - dsr;
      end
      quot <= {quot[6:0], div_ge};
      dsr  <= dsr >> 1;
    end
    if (cmd.mul_charge) begin
      rem_r <= rem_c;
      prod1 <= 24'(cfg.avg_time_to_empty_s) * 24'(rem_c) + 24'd50;
      low_r <= pwr < lim;
    end
    if (cmd.mul_recip) begin
      q_rt <= prod2[ubsm_pkg::RECIP_SHIFT +: 18];
    end
    if (cmd.finish) begin
      remaining_pct      <= rem_r;
      runtime_to_empty_s <= rt;
      status_word        <= st;
      send_report        <= report;
      send_runtime       <= report && dis;
      relay_pulse        <= watch_end && low_r;
      restore_ticks_left <= $signed(ticks);
    end
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      prev_status     <= '0;
      prev_remaining  <= '0;
      prev_runtime    <= '0;
      interval_timer  <= '0;
      outage_seen     <= 1'b0;
      restore_counter <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid       <= 1'b1;
        interval_timer  <= report ? 8'd0 : timer_inc;
        outage_seen     <= seen_next;
        restore_counter <= counter_next;
        if (report) begin
          prev_status    <= st;
          prev_remaining <= rem_r;
          prev_runtime   <= rt;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_finish_fills_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished result not presented");

  a_runtime_with_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_runtime) |-> (send_report && status_word[3]))
    else $error("runtime report without discharging report");

  a_pulse_on_mains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && relay_pulse) |-> status_word[1])
    else $error("relay pulse while on battery");

  a_counter_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !outage_seen |-> (restore_counter == 11'd0))
    else $error("restore counter running without outage");

endmodule
`default_nettype wire

>>> src/ups_battery_status_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ups_battery_status_monitor
// per-tick charge, runtime, status and report decision for a ups battery
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid / in_stall): one transaction per monitor tick with
//   mains_present, bus_voltage_mv, load_current_ma and shutdown_delay_s
// - output channel (out_valid / out_stall): exactly one result per tick
// - cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data): eight registers,
//   ready whenever reset is low; write only while no tick is in flight
// - sequence: a taken tick passes through prep, the bit-serial charge divider,
//   the runtime multiply and the divide-by-100 reciprocal multiply, then the
//   finish step into the output slot; a new tick is taken only once the
//   sequencer is back in idle after finish
// - the output slot is a register: a new tick is accepted while a result
//   still waits; if the receiver keeps out_stall high the next result holds
//   in the finish step and in_stall stays high until the slot frees
// - reset: synchronous, all history (previous status, charge, runtime,
//   interval timer, restore watch) cleared and registers loaded with defaults;
//   in_stall is high and cfg_ready low while reset is held; no clearing pass,
//   the block takes a tick in the first cycle after reset
// ----------------------------------------------------------------------------
module ups_battery_status_monitor (
  input  wire logic               clk,
  input  wire logic               rst,
  // tick input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mains_present,
  input  wire logic [15:0]        bus_voltage_mv,
  input  wire logic signed [16:0] load_current_ma,
  input  wire logic signed [15:0] shutdown_delay_s,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              remaining_pct,
  output logic [15:0]             runtime_to_empty_s,
  output logic [7:0]              status_word,
  output logic                    send_report,
  output logic                    send_runtime,
  output logic                    relay_pulse,
  output logic signed [10:0]      restore_ticks_left,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  ubsm_pkg::cfg_t cfg;
  ubsm_pkg::cmd_t cmd;
  ubsm_pkg::sts_t sts;

  // register file, index order matches the register list
  ubsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle -> prep -> 8 divide steps -> two multiplies -> finish
  ubsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, history registers and the output slot
  ubsm_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .mains_present      (mains_present),
    .bus_voltage_mv     (bus_voltage_mv),
    .load_current_ma    (load_current_ma),
    .shutdown_delay_s   (shutdown_delay_s),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .remaining_pct      (remaining_pct),
    .runtime_to_empty_s (runtime_to_empty_s),
    .status_word        (status_word),
    .send_report        (send_report),
    .send_runtime       (send_runtime),
    .relay_pulse        (relay_pulse),
    .restore_ticks_left (restore_ticks_left)
  );

endmodule
`default_nettype wire

>>> test/tb_ups_battery_status_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ups_battery_status_monitor
// self-checking bench for the ups battery status monitor: a directed table of
// ticks and register writes, then randomized phases with fresh register
// settings and random idling on both channels; every result transaction is
// compared field by field with a hand-computed value or with an in-bench model
// of the tick arithmetic, report decision and restore watch
// ----------------------------------------------------------------------------
module tb_ups_battery_status_monitor;

  localparam int     CLK_HALF     = 2;
  localparam int     RST_CYCLES   = 4;
  localparam int     LONG_HOLD    = 200;  // receiver hold-off, in cycles
  localparam int     DRAIN_CYCLES = 40;   // settle time after the last result
  localparam int     PHASES       = 8;
  localparam int     PHASE_TICKS  = 185;
  localparam int     MAX_REPORTS  = 200;  // cap on printed mismatch lines
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // status word bits
  localparam logic [7:0] ST_CHARGING    = 8'h01;
  localparam logic [7:0] ST_AC          = 8'h02;
  localparam logic [7:0] ST_FULL        = 8'h04;
  localparam logic [7:0] ST_DISCHARGING = 8'h08;
  localparam logic [7:0] ST_RTL_EXPIRED = 8'h10;
  localparam logic [7:0] ST_SHUTDOWN    = 8'h20;
  localparam logic [7:0] ST_IMMINENT    = 8'h40;
  localparam logic [7:0] ST_BATTERY     = 8'h80;

  // one monitor tick as it goes into the block
  typedef struct packed {
    logic               mains;
    logic [15:0]        volt;
    logic signed [16:0] cur;
    logic signed [15:0] sdly;
  } tick_t;

  // one result transaction as it leaves the block
  typedef struct packed {
    logic [7:0]         pct;
    logic [15:0]        runtime;
    logic [7:0]         status;
    logic               report;
    logic               runtime_due;
    logic               relay;
    logic signed [10:0] left;
  } reading_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    ubsm_pkg::cfg_idx_t idx;
    logic [15:0]        data;
    tick_t              t;
    int                 reps;
    bit                 typed;   // want holds a hand-computed result
    reading_t           want;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // dut signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic               clk              = 1'b0;
  logic               rst              = 1'b1;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic               mains_present    = 1'b0;
  logic [15:0]        bus_voltage_mv   = '0;
  logic signed [16:0] load_current_ma  = '0;
  logic signed [15:0] shutdown_delay_s = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [7:0]         remaining_pct;
  logic [15:0]        runtime_to_empty_s;
  logic [7:0]         status_word;
  logic               send_report;
  logic               send_runtime;
  logic               relay_pulse;
  logic signed [10:0] restore_ticks_left;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  ubsm_pkg::cfg_idx_t cfg_index        = ubsm_pkg::CFG_MIN_VOLTAGE;
  logic [15:0]        cfg_data         = '0;

  ups_battery_status_monitor DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mains_present      (mains_present),
    .bus_voltage_mv     (bus_voltage_mv),
    .load_current_ma    (load_current_ma),
    .shutdown_delay_s   (shutdown_delay_s),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .remaining_pct      (remaining_pct),
    .runtime_to_empty_s (runtime_to_empty_s),
    .status_word        (status_word),
    .send_report        (send_report),
    .send_runtime       (send_runtime),
    .relay_pulse        (relay_pulse),
    .restore_ticks_left (restore_ticks_left),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // model copy of the registers and history, starting from reset values
  // --------------------------------------------------------------------------
  logic [15:0] cfg_min       = ubsm_pkg::MIN_VOLTAGE_RST;
  logic [15:0] cfg_max       = ubsm_pkg::MAX_VOLTAGE_RST;
  logic [15:0] cfg_avg       = ubsm_pkg::AVG_TIME_RST;
  logic [15:0] cfg_rtl_limit = ubsm_pkg::REMAIN_LIMIT_RST;
  logic [7:0]  cfg_full      = ubsm_pkg::FULL_LEVEL_RST;
  logic [7:0]  cfg_interval  = ubsm_pkg::REPORT_INTERVAL_RST;
  logic [9:0]  cfg_timeout   = ubsm_pkg::RESTORE_TIMEOUT_RST;
  logic [15:0] cfg_low_load  = ubsm_pkg::LOW_LOAD_LIMIT_RST;

  logic [7:0]  hist_status   = '0;
  logic [7:0]  hist_pct      = '0;
  logic [15:0] hist_runtime  = '0;
  logic [7:0]  report_timer  = '0;
  logic        watch_active  = 1'b0;
  logic [10:0] restore_count = '0;

  reading_t  pending_readings[$];
  plan_row_t stim_table[$];

  // run bookkeeping
  int errors        = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int reports_seen  = 0;
  int runtime_seen  = 0;
  int pulses_seen   = 0;
  int reg_writes    = 0;

  // idling knobs, percent of cycles
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;

  // long receiver hold-off, requested by the stimulus, served by the receiver
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // random stimulus history: outage runs and steady voltages
  bit          on_battery = 1'b0;
  int unsigned last_volt  = 12000;

  // --------------------------------------------------------------------------
  // tick model: charge, runtime, status, report decision, restore watch
  // --------------------------------------------------------------------------
  function automatic reading_t next_reading(tick_t t);
    reading_t    r;
    int unsigned v, span, q;
    longint      load_x10, limit_x10;
    bit          on_bat, rtl, sreq, low;
    r      = '0;
    on_bat = !t.mains;

    // charge: rounded linear map, clamped below at min, saturating at 255
    if (cfg_max > cfg_min) begin
      v    = (t.volt < cfg_min) ? cfg_min : t.volt;
      span = cfg_max - cfg_min;
      q    = (200 * (v - cfg_min) + span) / (2 * span);
      r.pct = (q > 255) ? 8'd255 : q[7:0];
    end
    q = (cfg_avg * r.pct + 50) / 100;
    r.runtime = (q > 65535) ? 16'hFFFF : q[15:0];

    rtl  = on_bat && (r.runtime < cfg_rtl_limit);
    sreq = ($signed(t.sdly) > 0);
    r.status = ST_BATTERY;
    if (t.mains)              r.status |= ST_CHARGING | ST_AC;
    if (r.pct == cfg_full)    r.status |= ST_FULL;
    if (on_bat)               r.status |= ST_DISCHARGING;
    if (rtl)                  r.status |= ST_RTL_EXPIRED;
    if (sreq)                 r.status |= ST_SHUTDOWN;
    if (rtl || sreq)          r.status |= ST_IMMINENT;

    // saturating interval timer, report on change or on timer overrun
    report_timer = (report_timer > 8'd253) ? 8'd255 : report_timer + 8'd2;
    r.report = (r.status != hist_status) || (r.pct != hist_pct) ||
               (r.runtime != hist_runtime) || (report_timer > cfg_interval);
    if (r.report) begin
      report_timer = '0;
      hist_status  = r.status;
      hist_pct     = r.pct;
      hist_runtime = r.runtime;
    end
    r.runtime_due = r.report && on_bat;

    // restore watch
    if (on_bat) begin
      restore_count = '0;
      watch_active  = 1'b1;
    end
    r.left = {1'b0, cfg_timeout} - restore_count;
    if (watch_active && t.mains) begin
      load_x10  = $signed(t.cur);
      load_x10  = load_x10 * 122;
      limit_x10 = cfg_low_load;
      limit_x10 = limit_x10 * 10;
      low = (load_x10 < limit_x10);
      restore_count = restore_count + 11'd1;
      if (restore_count > {1'b0, cfg_timeout} || low) begin
        watch_active  = 1'b0;
        restore_count = '0;
        r.relay       = low;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus table helpers
  // --------------------------------------------------------------------------
  function automatic void plan_tick(bit m, int v, int c, int s, int reps = 1,
                                    bit typed = 1'b0, reading_t want = '0);
    plan_row_t row;
    row.kind  = ROW_TICK;
    row.idx   = ubsm_pkg::CFG_MIN_VOLTAGE;
    row.data  = '0;
    row.t     = {m, v[15:0], c[16:0], s[15:0]};
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endfunction

  function automatic void plan_cfg(ubsm_pkg::cfg_idx_t idx, int d);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = d[15:0];
    row.t     = '0;
    row.reps  = 0;
    row.typed = 1'b0;
    row.want  = '0;
    stim_table.push_back(row);
  endfunction

  // extremes forced by how (0 low, 1 high), else random with extremes mixed in
  function automatic int unsigned pick(int unsigned lo, int unsigned hi, int how);
    if (how == 0) return lo;
    if (how == 1) return hi;
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // random tick: runs of mains / battery with steady or moving voltage,
  // load mostly above the low-load limit so restore watches live on
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned lo, hi;
    int          thr, cur, sdly;
    if ($urandom_range(99) < 8) on_battery = !on_battery;
    if ($urandom_range(99) >= 40) begin
      lo = (cfg_min < cfg_max) ? cfg_min : cfg_max;
      hi = (cfg_min < cfg_max) ? cfg_max : cfg_min;
      lo = (lo > 300) ? lo - 300 : 0;
      hi = (hi + 300 > 36000) ? 36000 : hi + 300;
      last_volt = ($urandom_range(4) == 0) ? $urandom_range(36000)
                                           : $urandom_range(hi, lo);
    end
    thr = int'(cfg_low_load) * 10 / 122;
    case ($urandom_range(19))
      0, 1, 2, 3, 4: cur = int'($urandom_range(100000)) - 50000;
      5, 6, 7:       cur = thr - 2 + int'($urandom_range(4));
      default:       cur = int'($urandom_range(50000, thr + 1));
    endcase
    case ($urandom_range(19))
      14, 15:     sdly = 0;
      16, 17, 18: sdly = int'($urandom_range(32767, 1));
      19:         sdly = int'($urandom_range(32767));
      default:    sdly = -1;
    endcase
    t.mains = !on_battery;
    t.volt  = last_volt[15:0];
    t.cur   = cur[16:0];
    t.sdly  = sdly[15:0];
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers: inputs change at the falling edge
  // --------------------------------------------------------------------------
  task automatic send_tick(tick_t t, bit typed, reading_t want);
    reading_t model_out;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    mains_present    <= t.mains;
    bus_voltage_mv   <= t.volt;
    load_current_ma  <= t.cur;
    shutdown_delay_s <= t.sdly;
    do @(posedge clk); while (in_stall);
    // transaction taken: advance the model, queue what should come out
    model_out = next_reading(t);
    pending_readings.push_back(typed ? want : model_out);
    ticks_sent++;
  endtask

  // sender pause until every queued result has come out
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(ubsm_pkg::cfg_idx_t idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ubsm_pkg::CFG_MIN_VOLTAGE:     cfg_min       = d;
      ubsm_pkg::CFG_MAX_VOLTAGE:     cfg_max       = d;
      ubsm_pkg::CFG_AVG_TIME:        cfg_avg       = d;
      ubsm_pkg::CFG_REMAIN_LIMIT:    cfg_rtl_limit = d;
      ubsm_pkg::CFG_FULL_LEVEL:      cfg_full      = d[7:0];
      ubsm_pkg::CFG_REPORT_INTERVAL: cfg_interval  = d[7:0];
      ubsm_pkg::CFG_RESTORE_TIMEOUT: cfg_timeout   = d[9:0];
      ubsm_pkg::CFG_LOW_LOAD_LIMIT:  cfg_low_load  = d;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall, plus a long counted hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // result checking at the rising edge
  // --------------------------------------------------------------------------
  task automatic check_field(string field, longint want_v, longint got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    reading_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = {remaining_pct, runtime_to_empty_s, status_word, send_report,
             send_runtime, relay_pulse, restore_ticks_left};
      results_seen++;
      if (got.report)      reports_seen++;
      if (got.runtime_due) runtime_seen++;
      if (got.relay)       pulses_seen++;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0d ns: result transaction with no tick pending", $time);
      end else begin
        want = pending_readings.pop_front();
        check_field("remaining_pct", want.pct, got.pct);
        check_field("runtime_to_empty_s", want.runtime, got.runtime);
        check_field("status_word", want.status, got.status);
        check_field("send_report", want.report, got.report);
        check_field("send_runtime", want.runtime_due, got.runtime_due);
        check_field("relay_pulse", want.relay, got.relay);
        check_field("restore_ticks_left", $signed(want.left), $signed(got.left));
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          p, n, r, how;
    int unsigned span_pick;
    int unsigned cfg_vals[8];

    // directed part, hand-computed rows assume reset register values:
    // full-charge voltage on mains
    plan_tick(1, 13800, 1000, -1, 1, 1'b1,
              {8'd100, 16'd7200, ST_BATTERY | ST_FULL | ST_AC | ST_CHARGING,
               1'b1, 1'b0, 1'b0, 11'sd600});
    // zero volts on battery, max load, max shutdown delay: outage starts
    plan_tick(0, 0, 50000, 32767, 1, 1'b1,
              {8'd0, 16'd0, ST_BATTERY | ST_IMMINENT | ST_SHUTDOWN |
               ST_RTL_EXPIRED | ST_DISCHARGING, 1'b1, 1'b1, 1'b0, 11'sd600});
    // top voltage saturates charge; negative load on mains return counts
    // as low load and ends the watch with a relay pulse
    plan_tick(1, 36000, -50000, 0, 1, 1'b1,
              {8'd255, 16'd18360, ST_BATTERY | ST_AC | ST_CHARGING,
               1'b1, 1'b0, 1'b1, 11'sd600});
    // same tick again: nothing changed, timer far from its limit
    plan_tick(1, 36000, -50000, 0, 1, 1'b1,
              {8'd255, 16'd18360, ST_BATTERY | ST_AC | ST_CHARGING,
               1'b0, 1'b0, 1'b0, 11'sd600});
    // short interval gives a periodic report on a steady input
    plan_cfg(ubsm_pkg::CFG_REPORT_INTERVAL, 6);
    plan_tick(1, 13000, 1000, -1, 5);
    // outage, then mains back with real load: watch counts up
    plan_tick(0, 12000, 2000, 10, 2);
    plan_tick(1, 12500, 3000, -1, 4);
    // timeout lowered below the running count ends the watch at once
    plan_cfg(ubsm_pkg::CFG_RESTORE_TIMEOUT, 2);
    plan_tick(1, 12500, 3000, -1);
    // empty voltage span: equal, then inverted
    plan_cfg(ubsm_pkg::CFG_MAX_VOLTAGE, 11200);
    plan_tick(0, 13000, 0, -1);
    plan_cfg(ubsm_pkg::CFG_MAX_VOLTAGE, 0);
    plan_tick(1, 36000, 100, 100);
    plan_cfg(ubsm_pkg::CFG_MAX_VOLTAGE, 13800);
    // interval at 255 can never be passed by the saturating timer
    plan_cfg(ubsm_pkg::CFG_REPORT_INTERVAL, 255);
    plan_tick(1, 12000, 20000, -1, 3);
    // interval 0 reports on every tick
    plan_cfg(ubsm_pkg::CFG_REPORT_INTERVAL, 0);
    plan_tick(0, 12000, 20000, -1, 2);

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        wait_drain();
        write_reg(stim_table[i].idx, stim_table[i].data);
      end else begin
        for (n = 0; n < stim_table[i].reps; n++)
          send_tick(stim_table[i].t, stim_table[i].typed, stim_table[i].want);
      end
    end

    // random phases: first two at the register extremes, the rest random
    for (p = 0; p < PHASES; p++) begin
      wait_drain();
      how = (p < 2) ? p : 2;
      span_pick = 0;
      cfg_vals[ubsm_pkg::CFG_MIN_VOLTAGE] = pick(0, 36000, how);
      span_pick = cfg_vals[ubsm_pkg::CFG_MIN_VOLTAGE] + $urandom_range(6000, 200);
      cfg_vals[ubsm_pkg::CFG_MAX_VOLTAGE] = (how < 2 || $urandom_range(7) == 0) ?
                                            pick(0, 36000, how) :
                                            ((span_pick > 36000) ? 36000 : span_pick);
      cfg_vals[ubsm_pkg::CFG_AVG_TIME]     = pick(0, 65535, how);
      cfg_vals[ubsm_pkg::CFG_REMAIN_LIMIT] = pick(0, 65535, how);
      cfg_vals[ubsm_pkg::CFG_FULL_LEVEL]   = (how == 2) ? $urandom_range(100)
                                                        : pick(0, 255, how);
      cfg_vals[ubsm_pkg::CFG_REPORT_INTERVAL] = (p == 5) ? 255 : pick(0, 253, how);
      // short timeouts let restore watches run out within a mains run
      cfg_vals[ubsm_pkg::CFG_RESTORE_TIMEOUT] = (how == 2 && $urandom_range(1) == 0) ?
                                                $urandom_range(30) : pick(0, 1023, how);
      cfg_vals[ubsm_pkg::CFG_LOW_LOAD_LIMIT]  = pick(0, 65535, how);
      for (r = 0; r < 8; r++)
        write_reg(ubsm_pkg::cfg_idx_t'(r), 16'(cfg_vals[r]));

      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase

      for (n = 0; n < PHASE_TICKS; n++) begin
        // receiver holds off while the sender keeps pushing: input backs up
        if (p % 4 == 0 && n == PHASE_TICKS / 3) hold_asked++;
        if (n == PHASE_TICKS / 2) wait_drain();
        send_tick(random_tick(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d ticks, %0d results, %0d register writes, %0d mismatches",
             ticks_sent, results_seen, reg_writes, errors);
    $display("seen: %0d reports, %0d runtime reports, %0d relay pulses",
             reports_seen, runtime_seen, pulses_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", pending_readings.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
